// ===== hdl/skt_pkg.sv =====
// Shared types, command/status codes and key-byte folding for the sorted key table.
// No dependencies; imported by every module of the block.
package skt_pkg;

  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 16;
  localparam int POS_W    = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_RSVD     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [KEY_W-1:0]    search_key;
    logic [HANDLE_W-1:0] item_handle;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] found_handle;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    entries_held;
  } out_t;

  typedef struct packed {
    logic less;   // a orders below b
    logic equal;  // a equals b
  } cmp_res_t;

  // ASCII upper case folded to lower case
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'h20;
    end
    return b;
  endfunction

endpackage

// ===== hdl/skt_key_cmp.sv =====
// Case-insensitive bounded key comparator, shared by the search and match steps.
// Depends on skt_pkg (fold_byte, cmp_res_t).
module skt_key_cmp import skt_pkg::*; #(
  parameter int KEY_BYTES = 8
) (
  input  logic [8*KEY_BYTES-1:0] a,
  input  logic [8*KEY_BYTES-1:0] b,
  output cmp_res_t               res
);

  logic [7:0] xa;
  logic [7:0] xb;

  // Walk from the last byte to the first so the first deciding byte wins.
  always_comb begin
    res.less  = 1'b0;
    res.equal = 1'b1;
    xa = '0;
    xb = '0;
    for (int i = KEY_BYTES - 1; i >= 0; i--) begin
      xa = fold_byte(a[8*(KEY_BYTES-1-i) +: 8]);
      xb = fold_byte(b[8*(KEY_BYTES-1-i) +: 8]);
      if (xa != xb || xa == 8'h00) begin
        res.less  = (xa < xb);
        res.equal = (xa == xb);
      end
    end
  end

endmodule

// ===== hdl/skt_store.sv =====
// Entry memory: key and handle arrays, one write and one registered read per cycle.
// Depends on skt_pkg only through the import convention.
module skt_store import skt_pkg::*; #(
  parameter int DEPTH  = 64,
  parameter int KW     = 64,
  parameter int HW     = 16,
  parameter int AW     = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [KW-1:0] wkey,
  input  logic [HW-1:0] whandle,
  input  logic [AW-1:0] raddr,
  output logic [KW-1:0] rkey,
  output logic [HW-1:0] rhandle
);

  logic [KW-1:0] key_mem    [DEPTH];
  logic [HW-1:0] handle_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]    <= wkey;
      handle_mem[waddr] <= whandle;
    end
    rkey    <= key_mem[raddr];
    rhandle <= handle_mem[raddr];
  end

endmodule

// ===== hdl/sorted_key_table.sv =====
// Sorted key table: top level with the command sequencer.
// Depends on skt_pkg, skt_key_cmp and skt_store.
//
// Use: one command (insert, find, remove) is offered on in_valid/in_data and
// transferred when in_ready is high; in_ready is high only while the sequencer
// is idle. Each command gives exactly one result on out_valid/out_data.
// Sequence: every command runs a binary search, each probe a memory read
// (ST_SEARCH) and then a compare (ST_SCMP). Find, remove and the reserved code
// add a match compare (ST_CHECK). Insert and remove move the entries above
// the key one per cycle through the single memory port pair. The result sits
// in an output register; if the receiver stalls, the finished result waits
// there and the sequencer holds the next result until the register is free. A
// new command is taken once the result is loaded into the output register.
// Reset clears the entry count and the handshake state; the memory itself is
// not cleared, only entries below the count are ever used.
module sorted_key_table import skt_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int KEY_BYTES   = 8,
  parameter int HANDLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int KW = 8 * KEY_BYTES;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_SCMP, ST_CHECK, ST_SHUP, ST_SHDN, ST_WRITE, ST_RESP
  } state_t;

  state_t                 state_r;
  logic [1:0]             cmd_r;
  logic [KW-1:0]          key_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          lo_r;
  logic [CW-1:0]          hi_r;
  logic [AW-1:0]          src_r;
  logic [1:0]             status_r;
  logic [HANDLE_BITS-1:0] found_r;
  logic                   out_valid_r;
  out_t                   out_data_r;

  logic [CW-1:0]          mid_w;
  logic [CW-1:0]          cnt_m1;
  logic [CW-1:0]          lo_p1;
  logic [CW-1:0]          src_ext;
  logic [31:0]            in_h_ext;
  logic [31:0]            found_ext;
  logic [31:0]            pos_ext;
  logic [31:0]            cnt_ext;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [KW-1:0]          mem_wkey;
  logic [HANDLE_BITS-1:0] mem_whandle;
  logic [AW-1:0]          mem_raddr;
  logic [KW-1:0]          mem_rkey;
  logic [HANDLE_BITS-1:0] mem_rhandle;
  cmp_res_t               cmp;

  assign mid_w    = lo_r + ((hi_r - lo_r) >> 1);
  assign cnt_m1   = count_r - CW'(1);
  assign lo_p1    = lo_r + CW'(1);
  assign src_ext  = CW'(src_r);
  assign in_h_ext = 32'(in_data.item_handle);
  assign found_ext = 32'(found_r);
  assign pos_ext  = 32'(lo_r);
  assign cnt_ext  = 32'(count_r);

  skt_key_cmp #(.KEY_BYTES(KEY_BYTES)) u_cmp (
    .a   (mem_rkey),
    .b   (key_r),
    .res (cmp)
  );

  skt_store #(.DEPTH(CAPACITY), .KW(KW), .HW(HANDLE_BITS), .AW(AW)) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wkey    (mem_wkey),
    .whandle (mem_whandle),
    .raddr   (mem_raddr),
    .rkey    (mem_rkey),
    .rhandle (mem_rhandle)
  );

  // Memory port steering
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = src_r;
    mem_wkey    = mem_rkey;
    mem_whandle = mem_rhandle;
    mem_raddr   = src_r;
    unique case (state_r)
      ST_SEARCH: begin
        if (lo_r < hi_r) begin
          mem_raddr = mid_w[AW-1:0];
        end else if (cmd_r == CMD_INSERT) begin
          mem_raddr = cnt_m1[AW-1:0];
        end else begin
          mem_raddr = lo_r[AW-1:0];
        end
      end
      ST_CHECK: begin
        mem_raddr = lo_p1[AW-1:0];
      end
      ST_SHUP: begin
        // move entry src up by one, fetch the one below it
        mem_we    = 1'b1;
        mem_waddr = src_r + AW'(1);
        mem_raddr = src_r - AW'(1);
      end
      ST_SHDN: begin
        mem_we    = 1'b1;
        mem_waddr = src_r - AW'(1);
        mem_raddr = src_r + AW'(1);
      end
      ST_WRITE: begin
        mem_we      = 1'b1;
        mem_waddr   = lo_r[AW-1:0];
        mem_wkey    = key_r;
        mem_whandle = handle_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // ST_RESP handles the output register itself
      if (out_valid_r && out_ready && state_r != ST_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r    <= in_data.cmd;
            key_r    <= in_data.search_key[KW-1:0];
            handle_r <= in_h_ext[HANDLE_BITS-1:0];
            lo_r     <= '0;
            hi_r     <= count_r;
            status_r <= STAT_NOTFOUND;
            found_r  <= '0;
            state_r  <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (lo_r < hi_r) begin
            src_r   <= mid_w[AW-1:0];
            state_r <= ST_SCMP;
          end else if (cmd_r == CMD_INSERT) begin
            if (count_r >= CW'(CAPACITY)) begin
              status_r <= STAT_FULL;
              state_r  <= ST_RESP;
            end else if (count_r > lo_r) begin
              src_r   <= cnt_m1[AW-1:0];
              state_r <= ST_SHUP;
            end else begin
              state_r <= ST_WRITE;
            end
          end else if (lo_r < count_r) begin
            state_r <= ST_CHECK;
          end else begin
            state_r <= ST_RESP;
          end
        end
        ST_SCMP: begin
          if (cmp.less) begin
            lo_r <= src_ext + CW'(1);
          end else begin
            hi_r <= src_ext;
          end
          state_r <= ST_SEARCH;
        end
        ST_CHECK: begin
          if (cmp.equal) begin
            status_r <= STAT_OK;
            found_r  <= mem_rhandle;
            if (cmd_r == CMD_REMOVE) begin
              if (lo_p1 < count_r) begin
                src_r   <= lo_p1[AW-1:0];
                state_r <= ST_SHDN;
              end else begin
                count_r <= cnt_m1;
                state_r <= ST_RESP;
              end
            end else begin
              state_r <= ST_RESP;
            end
          end else begin
            state_r <= ST_RESP;
          end
        end
        ST_SHUP: begin
          if (src_ext > lo_r) begin
            src_r <= src_r - AW'(1);
          end else begin
            state_r <= ST_WRITE;
          end
        end
        ST_SHDN: begin
          if (src_ext + CW'(1) < count_r) begin
            src_r <= src_r + AW'(1);
          end else begin
            count_r <= cnt_m1;
            state_r <= ST_RESP;
          end
        end
        ST_WRITE: begin
          count_r  <= count_r + CW'(1);
          status_r <= STAT_OK;
          state_r  <= ST_RESP;
        end
        ST_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r             <= 1'b1;
            out_data_r.status       <= status_r;
            out_data_r.found_handle <= found_ext[HANDLE_W-1:0];
            out_data_r.position     <= pos_ext[POS_W-1:0];
            out_data_r.entries_held <= cnt_ext[POS_W-1:0];
            state_r                 <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Search window stays ordered and inside the table.
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH || state_r == ST_SCMP) |-> (lo_r <= hi_r && hi_r <= count_r))
    else $error("search window out of order");

  // Writes land only at or below the current count.
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CW'(mem_waddr) <= count_r))
    else $error("memory write beyond table end");

  // A full status is only reported with a full table.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && status_r == STAT_FULL) |-> (count_r == CW'(CAPACITY)))
    else $error("full status with free entries");

  // A result is loaded only into a free or draining output register.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && state_r == ST_RESP) |=> (state_r == ST_RESP))
    else $error("result overwrote a pending transfer");

endmodule

// ===== test/skt_table_checker_pkg.sv =====
// Scoreboard for the sorted key table: a predictor of the table contents
// and a queue of the results it expects. Depends on skt_pkg.
package skt_table_checker_pkg;
  import skt_pkg::*;

  localparam int TABLE_DEPTH = 64;

  class skt_table_checker;
    logic [KEY_W-1:0]    table_keys    [TABLE_DEPTH];
    logic [HANDLE_W-1:0] table_handles [TABLE_DEPTH];
    int unsigned held;
    int unsigned peak_held;
    out_t awaited [$];
    int unsigned errors;
    int unsigned mismatches;
    int unsigned checked;
    int unsigned n_insert, n_find, n_remove, n_full, n_hit;

    function new();
      held = 0;
      peak_held = 0;
      errors = 0;
      mismatches = 0;
      checked = 0;
      n_insert = 0;
      n_find = 0;
      n_remove = 0;
      n_full = 0;
      n_hit = 0;
    endfunction

    function logic [7:0] lower_case(logic [7:0] b);
      if (b >= 8'h41 && b <= 8'h5A) begin
        return b | 8'h20;
      end
      return b;
    endfunction

    // -1, 0, +1; case-folded, stops at the first zero byte
    function int key_order(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
      logic [7:0] x, y;
      for (int i = 0; i < 8; i++) begin
        x = lower_case(a[KEY_W-1-8*i -: 8]);
        y = lower_case(b[KEY_W-1-8*i -: 8]);
        if (x != y) begin
          return (x < y) ? -1 : 1;
        end
        if (x == 8'h00) begin
          return 0;
        end
      end
      return 0;
    endfunction

    function int unsigned lower_bound(logic [KEY_W-1:0] key);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = held;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (key_order(table_keys[mid], key) < 0) begin
          lo = mid + 1;
        end else begin
          hi = mid;
        end
      end
      return lo;
    endfunction

    function void note_input(in_t item);
      out_t res;
      int unsigned pos;
      pos = lower_bound(item.search_key);
      res.status = STAT_NOTFOUND;
      res.found_handle = '0;
      res.position = pos[POS_W-1:0];
      if (item.cmd == CMD_INSERT) begin
        n_insert++;
        if (held >= TABLE_DEPTH) begin
          res.status = STAT_FULL;
          n_full++;
        end else begin
          for (int i = held; i > int'(pos); i--) begin
            table_keys[i] = table_keys[i-1];
            table_handles[i] = table_handles[i-1];
          end
          table_keys[pos] = item.search_key;
          table_handles[pos] = item.item_handle;
          held++;
          res.status = STAT_OK;
        end
      end else begin
        if (item.cmd == CMD_REMOVE) n_remove++;
        else n_find++;
        if (pos < held && key_order(table_keys[pos], item.search_key) == 0) begin
          n_hit++;
          res.status = STAT_OK;
          res.found_handle = table_handles[pos];
          if (item.cmd == CMD_REMOVE) begin
            for (int i = pos; i + 1 < int'(held); i++) begin
              table_keys[i] = table_keys[i+1];
              table_handles[i] = table_handles[i+1];
            end
            held--;
          end
        end
      end
      if (held > peak_held) peak_held = held;
      res.entries_held = held[POS_W-1:0];
      awaited.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t exp;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("result transfer with nothing pending: %h", got);
        end
        return;
      end
      exp = awaited.pop_front();
      if (got.status !== exp.status || got.found_handle !== exp.found_handle ||
          got.position !== exp.position || got.entries_held !== exp.entries_held) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch: status %0d/%0d handle %h/%h pos %0d/%0d held %0d/%0d",
                   checked, exp.status, got.status, exp.found_handle, got.found_handle,
                   exp.position, got.position, exp.entries_held, got.entries_held);
        end
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // anything still queued at the end is a missing result
    function void close();
      if (awaited.size() != 0) begin
        errors += awaited.size();
        $display("%0d results never arrived", awaited.size());
      end
    endfunction
  endclass

endpackage

// ===== test/tb_sorted_key_table.sv =====
// Testbench top for sorted_key_table: directed and random command traffic
// with random idling on both channels. Depends on skt_pkg and skt_table_checker_pkg.
module tb_sorted_key_table import skt_pkg::*, skt_table_checker_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  skt_table_checker sb = new();
  int unsigned burst_left;

  sorted_key_table #(
    .CAPACITY(TABLE_DEPTH),
    .KEY_BYTES(8),
    .HANDLE_BITS(HANDLE_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [KEY_W-1:0] title(string s);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 8; i++) begin
      k[KEY_W-1-8*i -: 8] = s[i];
    end
    return k;
  endfunction

  function automatic in_t command(cmd_t c, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h);
    in_t item;
    item.cmd = c;
    item.search_key = k;
    item.item_handle = h;
    return item;
  endfunction

  // short titles over a small alphabet so that keys collide often
  function automatic logic [KEY_W-1:0] make_title();
    logic [KEY_W-1:0] k;
    logic [7:0] b;
    int len, r;
    k = '0;
    r = $urandom_range(0, 9);
    len = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 4) : $urandom_range(5, 8);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        b = 8'h61 + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1) b = b ^ 8'h20;
      end else begin
        case ($urandom_range(0, 2))
          0: b = 8'h5B + 8'($urandom_range(0, 5));  // punctuation between the cases
          1: b = 8'h30 + 8'($urandom_range(0, 9));
          default: b = 8'($urandom_range(8'h7B, 8'hFF));
        endcase
      end
      k[KEY_W-1-8*i -: 8] = b;
    end
    return k;
  endfunction

  // same key under strcasecmp order: letters flipped, maybe junk after the terminator
  function automatic logic [KEY_W-1:0] respell(logic [KEY_W-1:0] k);
    logic [7:0] b;
    int z;
    z = 8;
    for (int i = 0; i < 8; i++) begin
      b = k[KEY_W-1-8*i -: 8];
      if (z == 8 && b == 8'h00) z = i;
      if (z == 8 && ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) &&
          $urandom_range(0, 1) == 1) begin
        k[KEY_W-1-8*i -: 8] = b ^ 8'h20;
      end
    end
    if (z < 7 && $urandom_range(0, 4) == 0) begin
      for (int i = z + 1; i < 8; i++) begin
        k[KEY_W-1-8*i -: 8] = 8'($urandom_range(1, 255));
      end
    end
    return k;
  endfunction

  function automatic in_t random_command(phase_t ph);
    in_t item;
    int r, w_ins, w_find;
    bit reuse;
    item.item_handle = HANDLE_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 99) < 6) begin
      item.cmd = 2'($urandom_range(0, 3));
      item.search_key = {$urandom(), $urandom()};
      return item;
    end
    case (ph)
      PH_FILL: begin
        w_ins = 75;
        w_find = 15;
      end
      PH_DRAIN: begin
        w_ins = 12;
        w_find = 25;
      end
      default: begin
        w_ins = 40;
        w_find = 35;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < 2) item.cmd = CMD_RSVD;
    else if (r < w_ins + 2) item.cmd = CMD_INSERT;
    else if (r < w_ins + w_find + 2) item.cmd = CMD_FIND;
    else item.cmd = CMD_REMOVE;
    r = $urandom_range(0, 99);
    reuse = (item.cmd == CMD_INSERT) ? (r < 25) : (r < 75);
    if (reuse && sb.held > 0) begin
      item.search_key = respell(sb.table_keys[$urandom_range(0, sb.held - 1)]);
    end else begin
      item.search_key = make_title();
    end
    return item;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer, or after the idle that follows it
  task automatic push_command(in_t item);
    in_valid = 1'b1;
    in_data = item;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_input(item);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid = 1'b0;
      if ($urandom_range(0, 9) < 7) repeat ($urandom_range(1, 3)) @(negedge clk);
      else repeat ($urandom_range(4, 30)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // receiver: checks each result transfer and switches among four stall styles at random
  initial begin
    int mode, mode_left, stall_left;
    mode = 0;
    mode_left = 0;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
        sb.check_result(out_data);
      end
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (mode)
        0: out_ready = 1'b1;
        1: out_ready = ($urandom_range(0, 1) == 1);
        2: out_ready = ($urandom_range(0, 99) < 85);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ready = 1'b0;
          end else begin
            out_ready = 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(5, 30);
          end
        end
      endcase
    end
  end

  initial begin
    phase_t ph;
    int in_phase;
    int unsigned full_mark;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, key extremes, folding, equal keys, interior zero
    push_command(command(CMD_FIND, title("abc"), 16'h0000));
    push_command(command(CMD_REMOVE, title("abc"), 16'hFFFF));
    push_command(command(CMD_INSERT, '0, 16'h0000));
    push_command(command(CMD_INSERT, '1, 16'hFFFF));
    push_command(command(CMD_INSERT, title("Apple"), 16'h1234));
    push_command(command(CMD_INSERT, title("APPLE"), 16'hFFFF));
    push_command(command(CMD_FIND, title("apple"), 16'h0000));
    push_command(command(CMD_RSVD, title("aPPle"), 16'h5555));
    push_command(command(CMD_REMOVE, title("apple"), 16'h0000));
    push_command(command(CMD_FIND, title("APPLE"), 16'hAAAA));
    push_command(command(CMD_INSERT, title("_x"), 16'h0001));
    push_command(command(CMD_INSERT, title("Zed"), 16'h8000));
    push_command(command(CMD_INSERT, 64'h6162_007A_7A00_0000, 16'h00FF));
    push_command(command(CMD_FIND, 64'h4142_0071_71FF_FFFF, 16'h0000));
    push_command(command(CMD_REMOVE, title("ab"), 16'h0000));
    push_command(command(CMD_FIND, '0, 16'h0000));
    push_command(command(CMD_REMOVE, '1, 16'h0000));
    push_command(command(CMD_INSERT, title("abcdefgh"), 16'h7FFE));
    push_command(command(CMD_FIND, title("ABCDEFGH"), 16'h0000));
    push_command(command(CMD_FIND, title("abcdefgi"), 16'h0000));
    push_command(command(CMD_REMOVE, '0, 16'h0000));

    // random: fill to capacity, drain, mix, repeat
    ph = PH_FILL;
    in_phase = 0;
    full_mark = sb.n_full;
    for (int n = 0; n < 1830; n++) begin
      if (n == 900) begin
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      case (ph)
        PH_FILL: begin
          if ((sb.held == TABLE_DEPTH && sb.n_full >= full_mark + 4) || in_phase >= 250) begin
            ph = PH_DRAIN;
            in_phase = 0;
          end
        end
        PH_DRAIN: begin
          if (sb.held <= 1 || in_phase >= 250) begin
            ph = PH_MIXED;
            in_phase = 0;
          end
        end
        default: begin
          if (in_phase >= 150) begin
            ph = PH_FILL;
            in_phase = 0;
            full_mark = sb.n_full;
          end
        end
      endcase
      in_phase++;
      push_command(random_command(ph));
    end
    in_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    sb.close();
    $display("%0d commands: %0d inserts (%0d refused on a full table), %0d finds, %0d removes",
             sb.n_insert + sb.n_find + sb.n_remove, sb.n_insert, sb.n_full, sb.n_find,
             sb.n_remove);
    $display("%0d key matches, table reached %0d entries, %0d results checked",
             sb.n_hit, sb.peak_held, sb.checked);
    if (sb.errors == 0) begin
      $display("tb_sorted_key_table: clean");
    end else begin
      $display("tb_sorted_key_table: errors");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("tb_sorted_key_table: errors");
    $finish;
  end

endmodule
